// ===== src/ifd_pkg.sv =====
// ----------------------------------------------------------------------------
// ifd_pkg: shared types and codes of the image frame deframer
// Parser phases, result kinds, status codes and the result record.
// ----------------------------------------------------------------------------
package ifd_pkg;

   typedef enum logic [2:0] {
      PHASE_SIZE   = 3'd0,
      PHASE_STAMP  = 3'd1,
      PHASE_NLEN   = 3'd2,
      PHASE_NAME   = 3'd3,
      PHASE_WIDTH  = 3'd4,
      PHASE_HEIGHT = 3'd5,
      PHASE_PIXELS = 3'd6,
      PHASE_DONE   = 3'd7
   } ifd_phase_type;

   localparam logic [1:0] KIND_NAME   = 2'd0;
   localparam logic [1:0] KIND_PIXEL  = 2'd1;
   localparam logic [1:0] KIND_STATUS = 2'd2;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_MISMATCH = 2'd1;
   localparam logic [1:0] STATUS_EARLY    = 2'd2;

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  byte_value;
      logic [63:0] item_index;
      logic [63:0] frame_timestamp;
      logic [63:0] name_length;
      logic [31:0] image_width;
      logic [31:0] image_height;
      logic [1:0]  status;
      logic        end_of_run;
   } ifd_result_type;

   // Results caused by one beat: an optional name/pixel result, then an
   // optional status result.
   typedef struct packed {
      logic           data_valid;
      logic           stat_valid;
      ifd_result_type data;
      ifd_result_type stat;
   } ifd_emit_type;

endpackage

// ===== src/ifd_channels.sv =====
// ----------------------------------------------------------------------------
// ifd channels: request and response handshake interfaces
// Valid/ready channels carrying stream bytes in and parsed results out.
// ----------------------------------------------------------------------------
interface ifd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] stream_byte;
   logic       final_byte;

   modport source (output valid, output stream_byte, output final_byte, input ready);
   modport sink   (input valid, input stream_byte, input final_byte, output ready);
endinterface

interface ifd_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [7:0]  byte_value;
   logic [63:0] item_index;
   logic [63:0] frame_timestamp;
   logic [63:0] name_length;
   logic [31:0] image_width;
   logic [31:0] image_height;
   logic [1:0]  status;
   logic        end_of_run;

   modport source (output valid, output kind, output byte_value, output item_index,
                   output frame_timestamp, output name_length, output image_width,
                   output image_height, output status, output end_of_run, input ready);
   modport sink   (input valid, input kind, input byte_value, input item_index,
                   input frame_timestamp, input name_length, input image_width,
                   input image_height, input status, input end_of_run, output ready);
endinterface

// ===== src/image_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// image_frame_deframer: byte-serial image frame parser
// Usage:
//   req_bus carries one frame byte per beat (stream_byte) with final_byte
//   marking the last byte of the frame. rsp_bus carries results: a name
//   character or pixel with its index, and on the final byte an end-of-frame
//   status with the decoded header fields. The last result of a beat has
//   end_of_run set.
//   A result is registered and appears on rsp_bus in the cycle after its
//   beat is taken. Throughput: one byte per cycle while rsp_bus is ready.
//   A final byte that also carries a name character or pixel yields two
//   results; req_bus.ready is low until the second leaves the spare slot.
//   Reset (synchronous, active high) rearms the parser for a new frame and
//   empties the output register and the spare slot.
//   When the receiver stalls, the output register holds its result and
//   req_bus.ready drops unless the output register drains in the same cycle.
// ----------------------------------------------------------------------------
module image_frame_deframer (
   input  logic    clock,
   input  logic    reset,
   ifd_req_if.sink   req_bus,
   ifd_rsp_if.source rsp_bus
);

   ifd_pkg::ifd_emit_type   emit;
   ifd_pkg::ifd_result_type out_ff, out_in;
   ifd_pkg::ifd_result_type spare_ff, spare_in;
   logic out_valid_ff, out_valid_in;
   logic spare_valid_ff, spare_valid_in;
   logic accept;
   logic pop;

   // Take a beat only when the output register is free or draining and the
   // spare slot holds nothing.
   assign pop           = out_valid_ff && rsp_bus.ready;
   assign req_bus.ready = ~spare_valid_ff && (~out_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;

   ifd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .stream_byte (req_bus.stream_byte),
      .final_byte  (req_bus.final_byte),
      .emit        (emit)
   );

   // Load the output register from the parser, or advance the spare result.
   always_comb begin
      out_in         = out_ff;
      out_valid_in   = out_valid_ff && ~pop;
      spare_in       = spare_ff;
      spare_valid_in = spare_valid_ff;
      priority if (accept && emit.data_valid && emit.stat_valid) begin
         out_in         = emit.data;
         out_valid_in   = 1'b1;
         spare_in       = emit.stat;
         spare_valid_in = 1'b1;
      end else if (accept && emit.data_valid) begin
         out_in       = emit.data;
         out_valid_in = 1'b1;
      end else if (accept && emit.stat_valid) begin
         out_in       = emit.stat;
         out_valid_in = 1'b1;
      end else if (spare_valid_ff && (~out_valid_ff || pop)) begin
         out_in         = spare_ff;
         out_valid_in   = 1'b1;
         spare_valid_in = 1'b0;
      end else begin
         out_in = out_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         out_valid_ff   <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   // payload holds need no reset
   always_ff @(posedge clock) begin
      out_ff   <= out_in;
      spare_ff <= spare_in;
   end

   assign rsp_bus.valid           = out_valid_ff;
   assign rsp_bus.kind            = out_ff.kind;
   assign rsp_bus.byte_value      = out_ff.byte_value;
   assign rsp_bus.item_index      = out_ff.item_index;
   assign rsp_bus.frame_timestamp = out_ff.frame_timestamp;
   assign rsp_bus.name_length     = out_ff.name_length;
   assign rsp_bus.image_width     = out_ff.image_width;
   assign rsp_bus.image_height    = out_ff.image_height;
   assign rsp_bus.status          = out_ff.status;
   assign rsp_bus.end_of_run      = out_ff.end_of_run;

endmodule

// ===== src/ifd_parser.sv =====
// ----------------------------------------------------------------------------
// ifd_parser: frame header and payload parser
// Holds the parse state and forms the results of the current beat.
// ----------------------------------------------------------------------------
module ifd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          stream_byte,
   input  logic                final_byte,
   output ifd_pkg::ifd_emit_type emit
);

   ifd_pkg::ifd_phase_type phase_ff, phase_in, phase_step;
   logic [2:0]  pos_ff, pos_in;
   logic [63:0] received_ff, received_in;
   logic [63:0] declared_ff, declared_in;
   logic [63:0] stamp_ff, stamp_in;
   logic [63:0] nlen_ff, nlen_in;
   logic [63:0] chars_ff, chars_in;
   logic [63:0] pixel_ff, pixel_in;
   logic [31:0] width_ff, width_in;
   logic [31:0] height_ff, height_in;
   logic [31:0] column_ff, column_in;
   logic [31:0] row_ff, row_in;

   logic [63:0] lane;
   logic        last8;
   logic        last4;
   logic        column_wrap;

   assign lane        = {56'd0, stream_byte} << {pos_ff, 3'b000};
   assign last8       = (pos_ff == 3'd7);
   assign last4       = (pos_ff == 3'd3);
   assign column_wrap = ((column_ff + 32'd1) == width_ff);

   // next phase
   always_comb begin
      phase_step = phase_ff;
      unique case (phase_ff)
         ifd_pkg::PHASE_SIZE: begin
            if (last8) phase_step = ifd_pkg::PHASE_STAMP;
         end
         ifd_pkg::PHASE_STAMP: begin
            if (last8) phase_step = ifd_pkg::PHASE_NLEN;
         end
         ifd_pkg::PHASE_NLEN: begin
            if (last8) begin
               phase_step = (nlen_in == 64'd0) ? ifd_pkg::PHASE_WIDTH : ifd_pkg::PHASE_NAME;
            end
         end
         ifd_pkg::PHASE_NAME: begin
            if (chars_in == nlen_ff) phase_step = ifd_pkg::PHASE_WIDTH;
         end
         ifd_pkg::PHASE_WIDTH: begin
            if (last4) phase_step = ifd_pkg::PHASE_HEIGHT;
         end
         ifd_pkg::PHASE_HEIGHT: begin
            if (last4) begin
               phase_step = (width_ff == 32'd0 || height_in == 32'd0) ?
                            ifd_pkg::PHASE_DONE : ifd_pkg::PHASE_PIXELS;
            end
         end
         ifd_pkg::PHASE_PIXELS: begin
            if (column_wrap && (row_ff + 32'd1) == height_ff) begin
               phase_step = ifd_pkg::PHASE_DONE;
            end
         end
         ifd_pkg::PHASE_DONE: begin
            phase_step = ifd_pkg::PHASE_DONE;
         end
      endcase
      phase_in = final_byte ? ifd_pkg::PHASE_SIZE : phase_step;
   end

   // field assembly, counters and results
   always_comb begin
      pos_in      = pos_ff;
      received_in = received_ff + 64'd1;
      declared_in = declared_ff;
      stamp_in    = stamp_ff;
      nlen_in     = nlen_ff;
      chars_in    = chars_ff;
      pixel_in    = pixel_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      column_in   = column_ff;
      row_in      = row_ff;
      emit        = '0;

      unique case (phase_ff)
         ifd_pkg::PHASE_SIZE: begin
            declared_in = declared_ff | lane;
            pos_in      = pos_ff + 3'd1;
         end
         ifd_pkg::PHASE_STAMP: begin
            stamp_in = stamp_ff | lane;
            pos_in   = pos_ff + 3'd1;
         end
         ifd_pkg::PHASE_NLEN: begin
            nlen_in = nlen_ff | lane;
            pos_in  = pos_ff + 3'd1;
         end
         ifd_pkg::PHASE_NAME: begin
            emit.data_valid      = 1'b1;
            emit.data.kind       = ifd_pkg::KIND_NAME;
            emit.data.byte_value = stream_byte;
            emit.data.item_index = chars_ff;
            chars_in             = chars_ff + 64'd1;
         end
         ifd_pkg::PHASE_WIDTH: begin
            width_in = width_ff | lane[31:0];
            pos_in   = last4 ? 3'd0 : pos_ff + 3'd1;
         end
         ifd_pkg::PHASE_HEIGHT: begin
            height_in = height_ff | lane[31:0];
            pos_in    = last4 ? 3'd0 : pos_ff + 3'd1;
         end
         ifd_pkg::PHASE_PIXELS: begin
            emit.data_valid      = 1'b1;
            emit.data.kind       = ifd_pkg::KIND_PIXEL;
            emit.data.byte_value = stream_byte;
            emit.data.item_index = pixel_ff;
            pixel_in             = pixel_ff + 64'd1;
            if (column_wrap) begin
               column_in = 32'd0;
               row_in    = row_ff + 32'd1;
            end else begin
               column_in = column_ff + 32'd1;
            end
         end
         ifd_pkg::PHASE_DONE: begin
            pos_in = pos_ff;
         end
      endcase

      emit.data.end_of_run = ~final_byte;

      emit.stat_valid           = final_byte;
      emit.stat.kind            = ifd_pkg::KIND_STATUS;
      emit.stat.frame_timestamp = stamp_in;
      emit.stat.name_length     = nlen_in;
      emit.stat.image_width     = width_in;
      emit.stat.image_height    = height_in;
      emit.stat.end_of_run      = 1'b1;
      priority if (phase_step == ifd_pkg::PHASE_SIZE) begin
         emit.stat.status = ifd_pkg::STATUS_EARLY;
      end else if (declared_in != received_in) begin
         emit.stat.status = ifd_pkg::STATUS_MISMATCH;
      end else if (phase_step != ifd_pkg::PHASE_DONE) begin
         emit.stat.status = ifd_pkg::STATUS_EARLY;
      end else begin
         emit.stat.status = ifd_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && final_byte)) begin
         phase_ff    <= ifd_pkg::PHASE_SIZE;
         pos_ff      <= 3'd0;
         received_ff <= 64'd0;
         declared_ff <= 64'd0;
         stamp_ff    <= 64'd0;
         nlen_ff     <= 64'd0;
         chars_ff    <= 64'd0;
         pixel_ff    <= 64'd0;
         width_ff    <= 32'd0;
         height_ff   <= 32'd0;
         column_ff   <= 32'd0;
         row_ff      <= 32'd0;
      end else if (accept) begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         received_ff <= received_in;
         declared_ff <= declared_in;
         stamp_ff    <= stamp_in;
         nlen_ff     <= nlen_in;
         chars_ff    <= chars_in;
         pixel_ff    <= pixel_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         column_ff   <= column_in;
         row_ff      <= row_in;
      end
   end

endmodule

// ===== tb/sv/tb_image_frame_deframer.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_image_frame_deframer: self-checking bench for the image frame deframer
// Streams serialized frames (well-formed, truncated, padded, mis-sized and
// plain noise) into req_bus, predicts every name, pixel and status result
// in a local parser, and compares each rsp_bus beat field by field.
// ----------------------------------------------------------------------------
module tb_image_frame_deframer;

   localparam int CYCLE_LIMIT   = 300000;
   localparam int MAX_NAME_GEN  = 40;    // name bytes generated per frame at most
   localparam int MAX_PIXEL_GEN = 40;    // pixel bytes generated per frame at most

   logic clock = 1'b0;
   logic reset;

   ifd_req_if req_bus ();
   ifd_rsp_if rsp_bus ();

   image_frame_deframer u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // -------------------------------------------------------------------------
   // Parser mirror: state of the frame being decoded
   // -------------------------------------------------------------------------
   ifd_pkg::ifd_phase_type parse_phase;
   logic [2:0]     field_pos;
   logic [63:0]    byte_count;
   logic [63:0]    size_field;
   logic [63:0]    stamp_field;
   logic [63:0]    name_len_field;
   logic [63:0]    name_seen;
   logic [31:0]    width_field;
   logic [31:0]    height_field;
   logic [31:0]    pixel_col;
   logic [31:0]    pixel_row;

   // Results the deframer still owes, oldest first.
   ifd_pkg::ifd_result_type frame_results[$];

   int  error_count = 0;
   int  beats_sent  = 0;
   int  cycle_count = 0;
   bit  idle_on     = 1'b1;   // random gaps and stalls enabled
   int  stall_left  = 0;

   function automatic void clear_parser();
      parse_phase    = ifd_pkg::PHASE_SIZE;
      field_pos      = 3'd0;
      byte_count     = 64'd0;
      size_field     = 64'd0;
      stamp_field    = 64'd0;
      name_len_field = 64'd0;
      name_seen      = 64'd0;
      width_field    = 32'd0;
      height_field   = 32'd0;
      pixel_col      = 32'd0;
      pixel_row      = 32'd0;
   endfunction

   // Advance within a little-endian field of len bytes; true once the field is full.
   function automatic bit field_step(input int unsigned len);
      field_pos = field_pos + 3'd1;
      if (field_pos >= len || field_pos == 3'd0) begin
         field_pos = 3'd0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Decode one accepted beat and queue the results it must produce.
   function automatic void parse_byte(input logic [7:0] b, input logic fin);
      ifd_pkg::ifd_result_type data_res;
      ifd_pkg::ifd_result_type stat_res;
      logic [63:0]    lane;
      bit             have_data;

      lane      = {56'd0, b} << (8 * field_pos);
      have_data = 1'b0;
      data_res  = '0;
      byte_count = byte_count + 64'd1;

      case (parse_phase)
         ifd_pkg::PHASE_SIZE: begin
            size_field |= lane;
            if (field_step(8)) parse_phase = ifd_pkg::PHASE_STAMP;
         end
         ifd_pkg::PHASE_STAMP: begin
            stamp_field |= lane;
            if (field_step(8)) parse_phase = ifd_pkg::PHASE_NLEN;
         end
         ifd_pkg::PHASE_NLEN: begin
            name_len_field |= lane;
            if (field_step(8)) begin
               // empty name skips straight to the width field
               if (name_len_field == 64'd0) parse_phase = ifd_pkg::PHASE_WIDTH;
               else parse_phase = ifd_pkg::PHASE_NAME;
            end
         end
         ifd_pkg::PHASE_NAME: begin
            data_res.kind       = ifd_pkg::KIND_NAME;
            data_res.byte_value = b;
            data_res.item_index = name_seen;
            have_data = 1'b1;
            name_seen = name_seen + 64'd1;
            if (name_seen == name_len_field) parse_phase = ifd_pkg::PHASE_WIDTH;
         end
         ifd_pkg::PHASE_WIDTH: begin
            width_field |= lane[31:0];
            if (field_step(4)) parse_phase = ifd_pkg::PHASE_HEIGHT;
         end
         ifd_pkg::PHASE_HEIGHT: begin
            height_field |= lane[31:0];
            if (field_step(4)) begin
               // empty image: frame complete right after the header
               if (width_field == 32'd0 || height_field == 32'd0)
                  parse_phase = ifd_pkg::PHASE_DONE;
               else
                  parse_phase = ifd_pkg::PHASE_PIXELS;
            end
         end
         ifd_pkg::PHASE_PIXELS: begin
            data_res.kind       = ifd_pkg::KIND_PIXEL;
            data_res.byte_value = b;
            data_res.item_index = {32'd0, pixel_row} * {32'd0, width_field}
                                  + {32'd0, pixel_col};
            have_data = 1'b1;
            pixel_col = pixel_col + 32'd1;
            if (pixel_col == width_field) begin
               pixel_col = 32'd0;
               pixel_row = pixel_row + 32'd1;
               if (pixel_row == height_field) parse_phase = ifd_pkg::PHASE_DONE;
            end
         end
         default: begin
            // trailing bytes only bump the byte count
         end
      endcase

      if (have_data) begin
         data_res.end_of_run = !fin;
         frame_results.insert(frame_results.size(), data_res);
      end

      if (fin) begin
         stat_res                 = '0;
         stat_res.kind            = ifd_pkg::KIND_STATUS;
         stat_res.frame_timestamp = stamp_field;
         stat_res.name_length     = name_len_field;
         stat_res.image_width     = width_field;
         stat_res.image_height    = height_field;
         stat_res.end_of_run      = 1'b1;
         // size field incomplete wins, then the size check, then completeness
         if (parse_phase == ifd_pkg::PHASE_SIZE)
            stat_res.status = ifd_pkg::STATUS_EARLY;
         else if (size_field != byte_count)
            stat_res.status = ifd_pkg::STATUS_MISMATCH;
         else if (parse_phase != ifd_pkg::PHASE_DONE)
            stat_res.status = ifd_pkg::STATUS_EARLY;
         else
            stat_res.status = ifd_pkg::STATUS_OK;
         frame_results.insert(frame_results.size(), stat_res);
         clear_parser();
      end
   endfunction

   // -------------------------------------------------------------------------
   // Mismatch reporting and result checking
   // -------------------------------------------------------------------------
   task automatic report_mismatch(input string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(input string fname, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %h expected %h", fname, got, want));
   endtask

   // Sample each accepted result beat at the rising edge.
   always @(posedge clock) begin
      ifd_pkg::ifd_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (frame_results.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending, kind %0d",
                                      rsp_bus.kind));
         end else begin
            want = frame_results.pop_front();
            check_field("kind",            rsp_bus.kind,            want.kind);
            check_field("byte_value",      rsp_bus.byte_value,      want.byte_value);
            check_field("item_index",      rsp_bus.item_index,      want.item_index);
            check_field("frame_timestamp", rsp_bus.frame_timestamp, want.frame_timestamp);
            check_field("name_length",     rsp_bus.name_length,     want.name_length);
            check_field("image_width",     rsp_bus.image_width,     want.image_width);
            check_field("image_height",    rsp_bus.image_height,    want.image_height);
            check_field("status",          rsp_bus.status,          want.status);
            check_field("end_of_run",      rsp_bus.end_of_run,      want.end_of_run);
         end
      end
   end

   // Hard stop if the run hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Receiver: drop ready in random bursts while idling is on.
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_bus.ready <= 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus
   // -------------------------------------------------------------------------

   // Send one beat; entered and left at a falling edge. Valid stays high
   // into the next beat unless a gap is inserted.
   task automatic push_byte(input logic [7:0] b, input logic fin);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.stream_byte <= b;
      req_bus.final_byte  <= fin;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      parse_byte(b, fin);
      beats_sent++;
      @(negedge clock);
   endtask

   // Build one frame with random name and pixel bytes and stream it.
   // Oversized names or images are generated only in part, which truncates
   // the frame. cut > 0 ends the stream after at most that many bytes. The size
   // field holds the bytes actually sent plus size_delta.
   task automatic send_frame(input logic [63:0] stamp, input logic [63:0] nlen,
                             input logic [31:0] w, input logic [31:0] h,
                             input int trail, input logic [63:0] size_delta,
                             input int cut);
      logic [7:0]  stream[$];
      logic [63:0] npix;
      logic [63:0] declared;
      int          nname;
      int          npx;
      int          total;

      stream = {};
      repeat (8) stream.insert(stream.size(), 8'h00);   // size field, patched below
      for (int i = 0; i < 8; i++) stream.insert(stream.size(), stamp[8*i +: 8]);
      for (int i = 0; i < 8; i++) stream.insert(stream.size(), nlen[8*i +: 8]);
      nname = (nlen > MAX_NAME_GEN) ? MAX_NAME_GEN : int'(nlen[7:0]);
      for (int i = 0; i < nname; i++)
         stream.insert(stream.size(), 8'($urandom_range(0, 255)));
      if (nlen <= MAX_NAME_GEN) begin
         for (int i = 0; i < 4; i++) stream.insert(stream.size(), w[8*i +: 8]);
         for (int i = 0; i < 4; i++) stream.insert(stream.size(), h[8*i +: 8]);
         npix = {32'd0, w} * {32'd0, h};
         npx  = (npix > MAX_PIXEL_GEN) ? MAX_PIXEL_GEN : int'(npix[8:0]);
         for (int i = 0; i < npx; i++)
            stream.insert(stream.size(), 8'($urandom_range(0, 255)));
         if (npix <= MAX_PIXEL_GEN)
            repeat (trail) stream.insert(stream.size(), 8'($urandom_range(0, 255)));
      end

      total = (cut > 0 && cut < stream.size()) ? cut : stream.size();
      declared = 64'(total) + size_delta;
      for (int i = 0; i < 8; i++) stream[i] = declared[8*i +: 8];
      for (int i = 0; i < total; i++) push_byte(stream[i], i == total - 1);
   endtask

   // Random bytes, closed with a final byte so the next frame starts clean.
   task automatic send_noise(input int count);
      for (int i = 0; i < count; i++)
         push_byte(8'($urandom_range(0, 255)),
                   (i == count - 1) || ($urandom_range(0, 15) == 0));
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // Streams that end inside the header.
   task automatic test_short_streams();
      send_frame(rand64(), 64'd2, 32'd1, 32'd1, 0, 64'd0, 1);   // final on first byte
      send_frame(rand64(), 64'd2, 32'd1, 32'd1, 0, 64'd0, 5);   // size field partial
      send_frame(rand64(), 64'd2, 32'd1, 32'd1, 0, 64'd0, 8);   // size only
      send_frame(rand64(), 64'd0, 32'd3, 32'd1, 0, 64'd0, 26);  // stops inside width
   endtask

   // Complete frames, including empty name, empty image and padding.
   task automatic test_well_formed();
      send_frame(rand64(), 64'd0, 32'd0, 32'd3, 0, 64'd0, 0);
      send_frame(rand64(), 64'd1, 32'd3, 32'd0, 0, 64'd0, 0);
      send_frame(rand64(), 64'd3, 32'd2, 32'd2, 0, 64'd0, 0);
      send_frame(rand64(), 64'd2, 32'd2, 32'd1, 3, 64'd0, 0);   // trailing bytes
   endtask

   // Declared size off by one either way and far off.
   task automatic test_size_checks();
      send_frame(rand64(), 64'd1, 32'd1, 32'd2, 0, 64'd1, 0);
      send_frame(rand64(), 64'd0, 32'd2, 32'd1, 0, '1, 0);
      send_frame(rand64(), 64'd2, 32'd1, 32'd1, 2, 64'h8000_0000_0000_0000, 0);
   endtask

   // Frames cut inside the name and inside the pixels.
   task automatic test_truncation();
      send_frame(rand64(), 64'd4, 32'd2, 32'd2, 0, 64'd0, 26);
      send_frame(rand64(), 64'd1, 32'd3, 32'd3, 0, 64'd0, 38);
      send_frame(rand64(), 64'd0, 32'd4, 32'd2, 0, 64'd5, 36);
   endtask

   // Largest header values; the frames run out long before they complete.
   task automatic test_extremes();
      send_frame('1, '1, 32'd1, 32'd1, 0, 64'd0, 0);
      send_frame(64'd0, 64'd0, '1, '1, 0, 64'd0, 0);
      send_frame('1, 64'd0, 32'd1, '1, 0, 64'd0, 0);
      send_frame(rand64(), 64'd1, '1, 32'd1, 0, 64'd0, 0);
   endtask

   // Mostly well-formed frames with random content, the rest padded,
   // mis-sized, cut short or plain noise.
   task automatic test_random_frames(input int beat_goal);
      int          start;
      int          pick;
      logic [63:0] nlen;
      logic [31:0] w;
      logic [31:0] h;
      logic [63:0] delta;

      start = beats_sent;
      while (beats_sent - start < beat_goal) begin
         pick = $urandom_range(0, 99);
         nlen = 64'($urandom_range(0, 6));
         w    = $urandom_range(0, 5);
         h    = $urandom_range(0, 5);
         if (pick < 65) begin
            send_frame(rand64(), nlen, w, h, 0, 64'd0, 0);
         end else if (pick < 75) begin
            send_frame(rand64(), nlen, w, h, $urandom_range(1, 4), 64'd0, 0);
         end else if (pick < 83) begin
            case ($urandom_range(0, 2))
               0:       delta = 64'($urandom_range(1, 3));
               1:       delta = '1;
               default: delta = rand64();
            endcase
            send_frame(rand64(), nlen, w, h, 0, delta, 0);
         end else if (pick < 93) begin
            send_frame(rand64(), nlen, w, h, 0, 64'd0, $urandom_range(1, 60));
         end else begin
            send_noise($urandom_range(1, 12));
         end
      end
   endtask

   // Final stretch at full rate on both sides.
   task automatic test_full_rate();
      idle_on = 1'b0;
      test_random_frames(250);
   endtask

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.stream_byte = 8'h00;
      req_bus.final_byte  = 1'b0;
      rsp_bus.ready       = 1'b0;
      clear_parser();

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_short_streams();
      test_well_formed();
      test_size_checks();
      test_truncation();
      test_extremes();
      test_random_frames(650);
      test_full_rate();

      // Drain: hold valid low and wait for the last owed results.
      req_bus.valid <= 1'b0;
      while (frame_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== image_frame_deframer.f =====
src/ifd_pkg.sv
src/ifd_channels.sv
src/ifd_parser.sv
src/image_frame_deframer.sv
tb/sv/tb_image_frame_deframer.sv
